[design/tprx_pkg.sv]
// ----------------------------------------------------------------------------
// tprx_pkg
// Shared constants and codes for the typed packet receiver with XOR checksum.
// ----------------------------------------------------------------------------
package tprx_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int TYPE_COUNT  = 256;

    localparam int PAY_AW  = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int LEN_W   = $clog2(MAX_PAYLOAD + 1);
    localparam int TYPE_AW = (TYPE_COUNT > 1) ? $clog2(TYPE_COUNT) : 1;

    localparam logic [15:0] WINDOW_MAX = 16'hFFFF;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_FIRST  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HDR_SECOND = 1'd1;

    localparam logic [7:0] HDR_FIRST_RST  = 8'd170;
    localparam logic [7:0] HDR_SECOND_RST = 8'd85;

    localparam logic [1:0] FUNC_BYTE   = 2'd0;
    localparam logic [1:0] FUNC_SETLEN = 2'd1;
    localparam logic [1:0] FUNC_REPORT = 2'd2;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_REPORT  = 1'b1;

endpackage

[design/typed_packet_receiver_xor.sv]
// ----------------------------------------------------------------------------
// typed_packet_receiver_xor
// Frame parser: two header bytes, type, table-sized payload, XOR checksum.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_stall): one item per transfer. func 0 feeds a
// received byte, func 1 programs the payload length of a type, func 2 reports
// the reject counts and clears the window count.
// Output channel (o_valid / i_stall): payload bytes of a good frame (last one
// flagged) or a single counter report.
// A plain byte is taken without stalling the input. A type byte holds the
// input while the length table is read. A report waits in the report state
// while the output is stalled, then loads the output register. A good
// checksum byte drains the payload memory byte by byte (memory read, then
// output register load), during which o_stall stays high.
// Reset clears the parser, the counts and all length table valid bits;
// header values return to 0xAA and 0x55. While i_stall is high the output
// register holds its transfer and the block waits before loading the next.
// ----------------------------------------------------------------------------
module typed_packet_receiver_xor (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tprx_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tprx_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_func,
    input  logic [7:0]                        i_data_byte,
    input  logic [7:0]                        i_type_code,
    input  logic [7:0]                        i_payload_length,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_kind,
    output logic [7:0]                        o_frame_type,
    output logic [7:0]                        o_payload_byte,
    output logic [5:0]                        o_byte_index,
    output logic                              o_last,
    output logic [31:0]                       o_bad_total,
    output logic [15:0]                       o_bad_window
);

    localparam int PAY_AW  = tprx_pkg::PAY_AW;
    localparam int LEN_W   = tprx_pkg::LEN_W;
    localparam int TYPE_AW = tprx_pkg::TYPE_AW;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_LOOKUP  = 3'd1;
    localparam logic [2:0] ST_REPORT  = 3'd2;
    localparam logic [2:0] ST_EMIT_RD = 3'd3;
    localparam logic [2:0] ST_EMIT_WR = 3'd4;

    localparam logic [2:0] PH_HDR1 = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_TYPE = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CHK  = 3'd4;

    logic [7:0]        r_hdr1, r_hdr2;
    logic [2:0]        r_state, n_state;
    logic [2:0]        r_phase, n_phase;
    logic [7:0]        r_cur_type, n_cur_type;
    logic [LEN_W-1:0]  r_exp_len, n_exp_len;
    logic [LEN_W-1:0]  r_fill, n_fill;
    logic [7:0]        r_xor, n_xor;
    logic [LEN_W-1:0]  r_emit_idx, n_emit_idx;
    logic [31:0]       r_total, n_total;
    logic [15:0]       r_window, n_window;

    logic [7:0]        r_pay_mem [tprx_pkg::MAX_PAYLOAD];
    logic [7:0]        r_pay_rd;
    logic [LEN_W-1:0]  r_lt_mem [tprx_pkg::TYPE_COUNT];
    logic [LEN_W-1:0]  r_lt_rd;
    logic [tprx_pkg::TYPE_COUNT-1:0] r_lt_vld;
    logic              r_lt_rd_vld;

    logic              r_ov;
    logic              r_o_kind, r_o_last;
    logic [7:0]        r_o_type, r_o_byte;
    logic [5:0]        r_o_idx;
    logic [31:0]       r_o_total;
    logic [15:0]       r_o_window;

    logic              w_in_acc, w_out_free, w_reject;
    logic              w_pay_we, w_pay_re, w_lt_we, w_lt_re;
    logic [TYPE_AW-1:0] w_lt_addr;
    logic [LEN_W-1:0]  w_lt_wdata, w_len, w_fill_inc;
    logic              w_set_range, w_type_range, w_len_ok, w_emit_last;
    logic              w_load_rep, w_load_pay;

    assign o_stall    = (r_state != ST_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_ov || !i_stall;

    assign w_set_range  = ({1'b0, i_type_code} < 9'(tprx_pkg::TYPE_COUNT));
    assign w_type_range = ({1'b0, i_data_byte} < 9'(tprx_pkg::TYPE_COUNT));
    assign w_len_ok     = (i_payload_length != 8'd0) &&
                          ({1'b0, i_payload_length} <= 9'(tprx_pkg::MAX_PAYLOAD));
    assign w_lt_wdata   = w_len_ok ? LEN_W'(i_payload_length) : '0;
    assign w_lt_addr    = (i_func == tprx_pkg::FUNC_SETLEN) ?
                          i_type_code[TYPE_AW-1:0] : i_data_byte[TYPE_AW-1:0];
    assign w_len        = r_lt_rd_vld ? r_lt_rd : '0;
    assign w_fill_inc   = r_fill + LEN_W'(1);
    assign w_emit_last  = ((r_emit_idx + LEN_W'(1)) == r_exp_len);

    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_cur_type = r_cur_type;
        n_exp_len  = r_exp_len;
        n_fill     = r_fill;
        n_xor      = r_xor;
        n_emit_idx = r_emit_idx;
        w_reject   = 1'b0;
        w_pay_we   = 1'b0;
        w_pay_re   = 1'b0;
        w_lt_we    = 1'b0;
        w_lt_re    = 1'b0;
        w_load_rep = 1'b0;
        w_load_pay = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_func)
                        tprx_pkg::FUNC_BYTE: begin
                            unique case (r_phase)
                                PH_HDR1: begin
                                    if (i_data_byte == r_hdr1) n_phase = PH_HDR2;
                                end
                                PH_HDR2: begin
                                    if (i_data_byte == r_hdr2) begin
                                        n_phase = PH_TYPE;
                                    end else if (i_data_byte != r_hdr1) begin
                                        n_phase = PH_HDR1;
                                    end
                                end
                                PH_TYPE: begin
                                    n_cur_type = i_data_byte;
                                    if (w_type_range) begin
                                        w_lt_re = 1'b1;
                                        n_state = ST_LOOKUP;
                                    end else begin
                                        w_reject = 1'b1;
                                        n_phase  = PH_HDR1;
                                    end
                                end
                                PH_DATA: begin
                                    w_pay_we = 1'b1;
                                    n_xor    = r_xor ^ i_data_byte;
                                    n_fill   = w_fill_inc;
                                    if (w_fill_inc >= r_exp_len) n_phase = PH_CHK;
                                end
                                PH_CHK: begin
                                    if (r_xor == i_data_byte) begin
                                        n_emit_idx = '0;
                                        n_state    = ST_EMIT_RD;
                                    end else begin
                                        w_reject = 1'b1;
                                    end
                                    n_phase = PH_HDR1;
                                end
                                default: n_phase = PH_HDR1;
                            endcase
                        end
                        tprx_pkg::FUNC_SETLEN: begin
                            w_lt_we = w_set_range;
                        end
                        tprx_pkg::FUNC_REPORT: begin
                            n_state = ST_REPORT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOOKUP: begin
                if (w_len == '0) begin
                    w_reject = 1'b1;
                    n_phase  = PH_HDR1;
                end else begin
                    n_exp_len = w_len;
                    n_fill    = '0;
                    n_xor     = r_cur_type;
                    n_phase   = PH_DATA;
                end
                n_state = ST_IDLE;
            end
            ST_REPORT: begin
                if (w_out_free) begin
                    w_load_rep = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                w_pay_re = 1'b1;
                n_state  = ST_EMIT_WR;
            end
            ST_EMIT_WR: begin
                if (w_out_free) begin
                    w_load_pay = 1'b1;
                    if (w_emit_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_emit_idx = r_emit_idx + LEN_W'(1);
                        n_state    = ST_EMIT_RD;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_total  = r_total;
        n_window = r_window;
        if (w_reject) begin
            n_total = r_total + 32'd1;
            if (r_window != tprx_pkg::WINDOW_MAX) n_window = r_window + 16'd1;
        end else if (w_load_rep) begin
            n_window = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr1     <= tprx_pkg::HDR_FIRST_RST;
            r_hdr2     <= tprx_pkg::HDR_SECOND_RST;
            r_state    <= ST_IDLE;
            r_phase    <= PH_HDR1;
            r_cur_type <= '0;
            r_exp_len  <= '0;
            r_fill     <= '0;
            r_xor      <= '0;
            r_emit_idx <= '0;
            r_total    <= '0;
            r_window   <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == tprx_pkg::CFG_HDR_FIRST)  r_hdr1 <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_idx == tprx_pkg::CFG_HDR_SECOND) r_hdr2 <= i_cfg_wdata;
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_cur_type <= n_cur_type;
            r_exp_len  <= n_exp_len;
            r_fill     <= n_fill;
            r_xor      <= n_xor;
            r_emit_idx <= n_emit_idx;
            r_total    <= n_total;
            r_window   <= n_window;
            if (w_load_rep || w_load_pay) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (w_load_rep) begin
            r_o_kind   <= tprx_pkg::KIND_REPORT;
            r_o_type   <= '0;
            r_o_byte   <= '0;
            r_o_idx    <= '0;
            r_o_last   <= 1'b1;
            r_o_total  <= r_total;
            r_o_window <= r_window;
        end else if (w_load_pay) begin
            r_o_kind   <= tprx_pkg::KIND_PAYLOAD;
            r_o_type   <= r_cur_type;
            r_o_byte   <= r_pay_rd;
            r_o_idx    <= 6'(r_emit_idx);
            r_o_last   <= w_emit_last;
            r_o_total  <= '0;
            r_o_window <= '0;
        end
    end

    // payload memory
    always_ff @(posedge i_clk) begin
        if (w_pay_we) r_pay_mem[r_fill[PAY_AW-1:0]] <= i_data_byte;
        if (w_pay_re) r_pay_rd <= r_pay_mem[r_emit_idx[PAY_AW-1:0]];
    end

    // length table memory
    always_ff @(posedge i_clk) begin
        if (w_lt_we) r_lt_mem[w_lt_addr] <= w_lt_wdata;
        if (w_lt_re) r_lt_rd <= r_lt_mem[w_lt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt_vld    <= '0;
            r_lt_rd_vld <= 1'b0;
        end else begin
            if (w_lt_we) r_lt_vld[w_lt_addr] <= 1'b1;
            if (w_lt_re) r_lt_rd_vld <= r_lt_vld[w_lt_addr];
        end
    end

    assign o_valid        = r_ov;
    assign o_kind         = r_o_kind;
    assign o_frame_type   = r_o_type;
    assign o_payload_byte = r_o_byte;
    assign o_byte_index   = r_o_idx;
    assign o_last         = r_o_last;
    assign o_bad_total    = r_o_total;
    assign o_bad_window   = r_o_window;

endmodule

[design/tprx_checker.sv]
// ----------------------------------------------------------------------------
// tprx_checker
// Port-level checks for typed_packet_receiver_xor, bound to the top level.
// ----------------------------------------------------------------------------
module tprx_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [tprx_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tprx_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_valid,
    input  logic                              o_stall,
    input  logic [1:0]                        i_func,
    input  logic [7:0]                        i_data_byte,
    input  logic [7:0]                        i_type_code,
    input  logic [7:0]                        i_payload_length,
    input  logic                              o_valid,
    input  logic                              i_stall,
    input  logic                              o_kind,
    input  logic [7:0]                        o_frame_type,
    input  logic [7:0]                        o_payload_byte,
    input  logic [5:0]                        o_byte_index,
    input  logic                              o_last,
    input  logic [31:0]                       o_bad_total,
    input  logic [15:0]                       o_bad_window
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_index) && $stable(o_kind))
        else $error("output transfer changed while stalled");

    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == tprx_pkg::KIND_REPORT |->
            o_last && o_frame_type == 8'd0 && o_payload_byte == 8'd0 && o_byte_index == 6'd0)
        else $error("report transfer carries payload fields");

    a_payload_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == tprx_pkg::KIND_PAYLOAD |->
            o_bad_total == 32'd0 && o_bad_window == 16'd0)
        else $error("payload transfer carries counts");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    a_burst_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_kind == tprx_pkg::KIND_PAYLOAD && !o_last |->
            o_stall)
        else $error("input taken in the middle of a payload burst");

endmodule

bind typed_packet_receiver_xor tprx_checker u_tprx_checker (.*);

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for typed_packet_receiver_xor. A short directed table
// covers reset values, header resync, unregistered types and checksum
// failures; random phases then send mostly well-formed frames under several
// header settings, mixed with noise, table writes and count reports. Every
// output transfer is checked against a cycle-free parser model kept in the
// bench.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIMIT_CYCLES  = 2_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 2 * tprx_pkg::MAX_PAYLOAD + 16;
    localparam int PHASE_ITEMS   = 68;
    localparam int PHASE_COUNT   = 5;
    localparam int DIR_ROWS      = 24;

    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int MODE_GOOD   = 0;
    localparam int MODE_BADSUM = 1;
    localparam int MODE_SHORT  = 2;

    typedef enum logic [2:0] {
        PH_HDR1,
        PH_HDR2,
        PH_TYPE,
        PH_DATA,
        PH_CHK
    } t_parse_phase;

    typedef struct packed {
        logic [1:0] func;
        logic [7:0] data_byte;
        logic [7:0] type_code;
        logic [7:0] payload_length;
    } t_rx_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  frame_type;
        logic [7:0]  payload_byte;
        logic [5:0]  byte_index;
        logic        last;
        logic [31:0] bad_total;
        logic [15:0] bad_window;
    } t_rx_result;

    typedef struct packed {
        t_rx_item   item;
        logic       typed;
        t_rx_result res;
    } t_dir_row;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [tprx_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [tprx_pkg::CFG_DATA_W-1:0] i_cfg_wdata;
    logic                            i_valid;
    logic                            o_stall;
    logic [1:0]                      i_func;
    logic [7:0]                      i_data_byte;
    logic [7:0]                      i_type_code;
    logic [7:0]                      i_payload_length;
    logic                            o_valid;
    logic                            i_stall;
    logic                            o_kind;
    logic [7:0]                      o_frame_type;
    logic [7:0]                      o_payload_byte;
    logic [5:0]                      o_byte_index;
    logic                            o_last;
    logic [31:0]                     o_bad_total;
    logic [15:0]                     o_bad_window;

    typed_packet_receiver_xor u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_data_byte      (i_data_byte),
        .i_type_code      (i_type_code),
        .i_payload_length (i_payload_length),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_kind           (o_kind),
        .o_frame_type     (o_frame_type),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_last           (o_last),
        .o_bad_total      (o_bad_total),
        .o_bad_window     (o_bad_window)
    );

    // parser model state
    logic [7:0]   hdr_first;
    logic [7:0]   hdr_second;
    t_parse_phase parse_phase;
    logic [7:0]   cur_type;
    logic [6:0]   exp_len;
    logic [6:0]   fill_cnt;
    logic [7:0]   run_xor;
    logic [7:0]   pay_mem [0:tprx_pkg::MAX_PAYLOAD-1];
    logic [6:0]   type_len [0:tprx_pkg::TYPE_COUNT-1];
    logic [31:0]  rej_total;
    logic [15:0]  rej_window;

    t_rx_result   pending_out_q [$];
    logic [7:0]   reg_types [$];
    t_dir_row     dir_rows [0:DIR_ROWS-1];
    int           errors;
    int           sent;
    bit           idle_on;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic void reset_model();
        int k;
        hdr_first   = tprx_pkg::HDR_FIRST_RST;
        hdr_second  = tprx_pkg::HDR_SECOND_RST;
        parse_phase = PH_HDR1;
        cur_type    = '0;
        exp_len     = '0;
        fill_cnt    = '0;
        run_xor     = '0;
        rej_total   = '0;
        rej_window  = '0;
        for (k = 0; k < tprx_pkg::TYPE_COUNT; k++) type_len[k] = '0;
    endfunction

    function automatic void count_reject();
        rej_total = rej_total + 32'd1;
        if (rej_window != tprx_pkg::WINDOW_MAX) rej_window = rej_window + 16'd1;
    endfunction

    function automatic void parse_byte(logic [7:0] b, bit emit);
        int k;
        t_rx_result r;
        unique case (parse_phase)
            PH_HDR1: begin
                if (b == hdr_first) parse_phase = PH_HDR2;
            end
            PH_HDR2: begin
                if (b == hdr_second) parse_phase = PH_TYPE;
                else if (b != hdr_first) parse_phase = PH_HDR1;
            end
            PH_TYPE: begin
                cur_type = b;
                if (type_len[b] == 0) begin
                    count_reject();
                    parse_phase = PH_HDR1;
                end else begin
                    exp_len     = type_len[b];
                    fill_cnt    = '0;
                    run_xor     = b;
                    parse_phase = PH_DATA;
                end
            end
            PH_DATA: begin
                pay_mem[fill_cnt[5:0]] = b;
                run_xor  = run_xor ^ b;
                fill_cnt = fill_cnt + 7'd1;
                if (fill_cnt >= exp_len) parse_phase = PH_CHK;
            end
            PH_CHK: begin
                if (run_xor == b) begin
                    for (k = 0; k < exp_len; k++) begin
                        r              = '0;
                        r.kind         = tprx_pkg::KIND_PAYLOAD;
                        r.frame_type   = cur_type;
                        r.payload_byte = pay_mem[k];
                        r.byte_index   = k[5:0];
                        r.last         = (k + 1 == exp_len);
                        if (emit) pending_out_q.push_back(r);
                    end
                end else begin
                    count_reject();
                end
                parse_phase = PH_HDR1;
            end
            default: parse_phase = PH_HDR1;
        endcase
    endfunction

    function automatic void parse_item(t_rx_item it, bit emit);
        t_rx_result r;
        unique case (it.func)
            tprx_pkg::FUNC_BYTE: parse_byte(it.data_byte, emit);
            tprx_pkg::FUNC_SETLEN: begin
                if (it.payload_length >= 1 && it.payload_length <= tprx_pkg::MAX_PAYLOAD)
                    type_len[it.type_code] = it.payload_length[6:0];
                else
                    type_len[it.type_code] = '0;
            end
            tprx_pkg::FUNC_REPORT: begin
                r            = '0;
                r.kind       = tprx_pkg::KIND_REPORT;
                r.last       = 1'b1;
                r.bad_total  = rej_total;
                r.bad_window = rej_window;
                if (emit) pending_out_q.push_back(r);
                rej_window = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic t_rx_item mk_item(logic [1:0] f, logic [7:0] d, logic [7:0] t,
                                         logic [7:0] l);
        t_rx_item it;
        it.func           = f;
        it.data_byte      = d;
        it.type_code      = t;
        it.payload_length = l;
        return it;
    endfunction

    function automatic t_rx_item rand_item(logic [1:0] f);
        return mk_item(f, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)));
    endfunction

    function automatic t_rx_result rep(logic [31:0] total, logic [15:0] win);
        t_rx_result r;
        r            = '0;
        r.kind       = tprx_pkg::KIND_REPORT;
        r.last       = 1'b1;
        r.bad_total  = total;
        r.bad_window = win;
        return r;
    endfunction

    function automatic t_dir_row row(logic [1:0] f, logic [7:0] d, logic [7:0] t,
                                     logic [7:0] l, logic typed, t_rx_result res);
        t_dir_row x;
        x.item  = mk_item(f, d, t, l);
        x.typed = typed;
        x.res   = res;
        return x;
    endfunction

    function automatic logic [7:0] pick_len();
        int r;
        r = int'($urandom_range(0, 19));
        if (r < 14) return 8'($urandom_range(1, 8));
        if (r < 16) return 8'(tprx_pkg::MAX_PAYLOAD);
        if (r < 17) return 8'd0;
        if (r < 18) return 8'($urandom_range(tprx_pkg::MAX_PAYLOAD + 1, 255));
        return 8'($urandom_range(9, tprx_pkg::MAX_PAYLOAD - 1));
    endfunction

    function automatic logic [7:0] pick_type();
        if (reg_types.size() != 0 && $urandom_range(0, 6) != 0)
            return reg_types[$urandom_range(0, reg_types.size() - 1)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic send_item(t_rx_item it, logic typed, t_rx_result res);
        int gap;
        gap = idle_on ? int'($urandom_range(0, 5)) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_func           <= it.func;
        i_data_byte      <= it.data_byte;
        i_type_code      <= it.type_code;
        i_payload_length <= it.payload_length;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        parse_item(it, !typed);
        if (typed) pending_out_q.push_back(res);
        if (it.func != FUNC_NONE) sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        t_rx_item it;
        it           = rand_item(tprx_pkg::FUNC_BYTE);
        it.data_byte = b;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_setlen(logic [7:0] t, logic [7:0] l);
        t_rx_item it;
        it                = rand_item(tprx_pkg::FUNC_SETLEN);
        it.type_code      = t;
        it.payload_length = l;
        send_item(it, 1'b0, '0);
    endtask

    task automatic send_frame(logic [7:0] ftype, int mode);
        int n;
        int k;
        logic [7:0] sum;
        if (hdr_first != hdr_second && $urandom_range(0, 4) == 0) send_byte(hdr_first);
        send_byte(hdr_first);
        send_byte(hdr_second);
        send_byte(ftype);
        if (parse_phase != PH_DATA) return;
        n = int'(exp_len);
        if (mode == MODE_SHORT) n = int'($urandom_range(0, n - 1));
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 24) == 0)
                send_setlen($urandom_range(0, 1) ? ftype : 8'($urandom_range(0, 255)),
                            pick_len());
            send_byte(8'($urandom_range(0, 255)));
        end
        if (mode == MODE_SHORT) return;
        sum = run_xor;
        if (mode == MODE_BADSUM) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_out_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_headers(logic [7:0] first, logic [7:0] second);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= tprx_pkg::CFG_HDR_FIRST;
        i_cfg_wdata <= first;
        @(posedge i_clk);
        hdr_first   = first;
        i_cfg_idx   <= tprx_pkg::CFG_HDR_SECOND;
        i_cfg_wdata <= second;
        @(posedge i_clk);
        hdr_second  = second;
        i_cfg_we    <= 1'b0;
    endtask

    // output side: check each transfer, then stall for a random count while idle_on is set
    initial begin
        int hold;
        logic nxt;
        t_rx_result got;
        t_rx_result want;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            nxt = 1'b0;
            if (i_rst_n && o_valid && !i_stall) begin
                got = '{o_kind, o_frame_type, o_payload_byte, o_byte_index, o_last,
                        o_bad_total, o_bad_window};
                if (pending_out_q.size() == 0) begin
                    $display("%0t: result expected none actual kind %0h type %0h byte %0h",
                             $time, got.kind, got.frame_type, got.payload_byte);
                    errors++;
                end else begin
                    want = pending_out_q.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(got.payload_byte));
                    check_field("byte_index", 32'(want.byte_index), 32'(got.byte_index));
                    check_field("last", 32'(want.last), 32'(got.last));
                    check_field("bad_total", want.bad_total, got.bad_total);
                    check_field("bad_window", 32'(want.bad_window), 32'(got.bad_window));
                end
                hold = idle_on ? int'($urandom_range(0, 5)) : 0;
            end
            if (hold > 0) begin
                nxt = 1'b1;
                hold--;
            end
            i_stall <= nxt;
        end
    end

    initial begin
        int cycle_cnt;
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("typed_packet_receiver_xor: mismatch");
        $finish;
    end

    initial begin
        int k;
        int p;
        int r;
        int phase_start;
        logic [7:0] ha;
        logic [7:0] hb;
        logic [7:0] t;
        logic [7:0] l;
        errors           = 0;
        sent             = 0;
        idle_on          = 1'b1;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_wdata      = '0;
        i_valid          = 1'b0;
        i_func           = tprx_pkg::FUNC_BYTE;
        i_data_byte      = '0;
        i_type_code      = '0;
        i_payload_length = '0;
        reset_model();

        dir_rows[0]  = row(tprx_pkg::FUNC_REPORT, 8'h00, 8'h00, 8'h00, 1'b1,
                           rep(32'd0, 16'd0));
        dir_rows[1]  = row(FUNC_NONE,             8'hFF, 8'hFF, 8'hFF, 1'b0, '0);
        dir_rows[2]  = row(tprx_pkg::FUNC_SETLEN, 8'h00, 8'h00, 8'd1,  1'b0, '0);
        dir_rows[3]  = row(tprx_pkg::FUNC_SETLEN, 8'hFF, 8'hFF, 8'd64, 1'b0, '0);
        dir_rows[4]  = row(tprx_pkg::FUNC_SETLEN, 8'h00, 8'h10, 8'd65, 1'b0, '0);
        dir_rows[5]  = row(tprx_pkg::FUNC_SETLEN, 8'h00, 8'h11, 8'd0,  1'b0, '0);
        dir_rows[6]  = row(tprx_pkg::FUNC_BYTE,   8'hAA, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[7]  = row(tprx_pkg::FUNC_BYTE,   8'hAA, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[8]  = row(tprx_pkg::FUNC_BYTE,   8'h55, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[9]  = row(tprx_pkg::FUNC_BYTE,   8'h10, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[10] = row(tprx_pkg::FUNC_BYTE,   8'hAA, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[11] = row(tprx_pkg::FUNC_BYTE,   8'h00, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[12] = row(tprx_pkg::FUNC_BYTE,   8'hAA, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[13] = row(tprx_pkg::FUNC_BYTE,   8'h55, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[14] = row(tprx_pkg::FUNC_BYTE,   8'h00, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[15] = row(tprx_pkg::FUNC_BYTE,   8'hFF, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[16] = row(tprx_pkg::FUNC_BYTE,   8'hFF, 8'h00, 8'h00, 1'b1,
                           '{tprx_pkg::KIND_PAYLOAD, 8'h00, 8'hFF, 6'd0, 1'b1,
                             32'd0, 16'd0});
        dir_rows[17] = row(tprx_pkg::FUNC_BYTE,   8'hAA, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[18] = row(tprx_pkg::FUNC_BYTE,   8'h55, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[19] = row(tprx_pkg::FUNC_BYTE,   8'h00, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[20] = row(tprx_pkg::FUNC_BYTE,   8'h12, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[21] = row(tprx_pkg::FUNC_BYTE,   8'h00, 8'h00, 8'h00, 1'b0, '0);
        dir_rows[22] = row(tprx_pkg::FUNC_REPORT, 8'h00, 8'h00, 8'h00, 1'b1,
                           rep(32'd2, 16'd2));
        dir_rows[23] = row(tprx_pkg::FUNC_REPORT, 8'h00, 8'h00, 8'h00, 1'b1,
                           rep(32'd2, 16'd0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].res);

        for (p = 0; p < PHASE_COUNT; p++) begin
            wait_idle();
            ha = 8'($urandom_range(0, 255));
            hb = ha ^ 8'($urandom_range(1, 255));
            unique case (p)
                0: set_headers(tprx_pkg::HDR_FIRST_RST, tprx_pkg::HDR_SECOND_RST);
                1: set_headers(8'h00, 8'hFF);
                2: set_headers(8'hFF, 8'h00);
                3: set_headers(ha, hb);
                default: set_headers(ha, ha);
            endcase
            idle_on = (p != 2);
            reg_types.delete();
            if (p == 0) begin
                send_setlen(8'hFF, 8'(tprx_pkg::MAX_PAYLOAD));
                reg_types.push_back(8'hFF);
            end
            repeat (6) begin
                t = 8'($urandom_range(0, 255));
                l = pick_len();
                send_setlen(t, l);
                if (l >= 1 && l <= tprx_pkg::MAX_PAYLOAD) reg_types.push_back(t);
            end
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS) begin
                if (p != 2 && $urandom_range(0, 29) == 0) idle_on = $urandom_range(0, 3) != 0;
                r = int'($urandom_range(0, 99));
                if (r < 70)
                    send_frame(pick_type(),
                               ($urandom_range(0, 9) == 0) ? MODE_BADSUM : MODE_GOOD);
                else if (r < 80)
                    send_byte(8'($urandom_range(0, 255)));
                else if (r < 88)
                    send_setlen(8'($urandom_range(0, 255)), pick_len());
                else if (r < 95)
                    send_item(rand_item(tprx_pkg::FUNC_REPORT), 1'b0, '0);
                else if (r < 97)
                    send_item(rand_item(FUNC_NONE), 1'b0, '0);
                else
                    send_frame(pick_type(), MODE_SHORT);
            end
        end

        wait_idle();
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("typed_packet_receiver_xor: match");
        else
            $display("typed_packet_receiver_xor: mismatch");
        $finish;
    end

endmodule

[files.f]
design/tprx_pkg.sv
design/typed_packet_receiver_xor.sv
design/tprx_checker.sv
bench/testbench.sv
